[rtl/cfa_pkg.sv]
// Package for the chunk fit allocator: sizing defaults, operation and fit codes,
// register indexes, and the command and result structs.
// No dependencies.
package cfa_pkg;

  // Default sizing
  localparam int unsigned MaxChunksDef = 16;
  localparam int unsigned SizeBitsDef  = 16;

  // Fixed field widths
  localparam int unsigned OpW      = 2;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned FieldW   = 16;
  localparam int unsigned FitW     = 2;
  localparam int unsigned ChunksW  = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Command opcodes
  typedef enum logic [OpW-1:0] {
    OP_WRITE   = 2'd0,
    OP_RESTORE = 2'd1,
    OP_ALLOC   = 2'd2
  } cfa_op_e;

  // Placement policies; the unused code behaves as first fit
  typedef enum logic [FitW-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } cfa_fit_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIT_MODE = 2'd0,
    CFG_CHUNKS   = 2'd1
  } cfa_cfg_e;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [SlotW-1:0]  slot;
    logic [FieldW-1:0] size;
  } cfa_item_t;

  typedef struct packed {
    logic              found;
    logic [SlotW-1:0]  chosen_slot;
    logic [FieldW-1:0] remaining_before;
    logic [FieldW-1:0] original_size;
  } cfa_result_t;

endpackage

[rtl/chunk_fit_allocator.sv]
// Chunk fit allocator top level: command sequencer, chunk size memories, fit compare.
// Depends on cfa_pkg, cfa_ram and cfa_fit_cmp.
//
// A command is taken when start_i is high and busy_o low; busy_o stays high until
// the command is finished. A slot write keeps busy_o high for 1 cycle. A restore
// copies every slot, one per cycle through the memory read port. An allocate scans
// the first n = min(chunks_in_use, MaxChunks) slots one per cycle through the single
// compare unit; its result appears with done_o for exactly one cycle, in the same
// cycle in which busy_o falls, and the receiver cannot stall it. The next command
// can be taken as soon as busy_o is low. Configuration writes are taken at any time
// but are meant for idle.
module chunk_fit_allocator import cfa_pkg::*; #(
  parameter int unsigned MaxChunks = MaxChunksDef,
  parameter int unsigned SizeBits  = SizeBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Command channel
  input  logic                start_i,
  input  cfa_item_t           item_i,
  output logic                busy_o,
  // Result channel
  output logic                done_o,
  output cfa_result_t         result_o,
  // Configuration channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam int unsigned CntW  = $clog2(MaxChunks + 1);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_WRITE   = 6'b000010,
    ST_RESTORE = 6'b000100,
    ST_SCAN    = 6'b001000,
    ST_FETCH   = 6'b010000,
    ST_REPLY   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [FitW-1:0]      fit_mode_q;
  logic [ChunksW-1:0]   chunks_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 chk_vld_q, chk_vld_d;
  logic                 hit_q, hit_d;
  logic                 done_q, done_d;
  cfa_item_t            item_q;
  logic [AddrW-1:0]     chk_idx_q;
  logic [AddrW-1:0]     best_q, best_d;
  logic [SizeBits-1:0]  best_val_q, best_val_d;
  cfa_result_t          result_q, result_d;

  logic                 accept;
  logic [CntW-1:0]      n_scan;
  logic [CntW-1:0]      limit;
  logic                 issue;
  logic [SizeBits-1:0]  req;
  logic                 slot_ok;
  logic                 take;

  logic                 orig_we;
  logic [AddrW-1:0]     orig_raddr;
  logic [SizeBits-1:0]  orig_rdata;
  logic                 rem_we;
  logic [AddrW-1:0]     rem_waddr;
  logic [SizeBits-1:0]  rem_wdata;
  logic [SizeBits-1:0]  rem_rdata;

  assign accept      = start_i && (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = result_q;

  assign req     = SizeBits'(item_q.size);
  assign slot_ok = (32'(item_q.slot) < MaxChunks);

  // Slots taking part in a scan, clamped to the table depth
  always_comb begin
    if (32'(chunks_q) > MaxChunks) begin
      n_scan = CntW'(MaxChunks);
    end else begin
      n_scan = CntW'(chunks_q);
    end
  end

  assign limit = (state_q == ST_RESTORE) ? CntW'(MaxChunks) : n_scan;
  assign issue = ((state_q == ST_SCAN) || (state_q == ST_RESTORE)) && (cnt_q < limit);

  // Memory ports
  assign orig_we    = (state_q == ST_WRITE) && slot_ok;
  assign orig_raddr = (state_q == ST_FETCH) ? best_q : cnt_q[AddrW-1:0];

  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = AddrW'(item_q.slot);
    rem_wdata = req;
    unique case (state_q)
      ST_WRITE: begin
        rem_we = slot_ok;
      end
      ST_RESTORE: begin
        rem_we    = chk_vld_q;
        rem_waddr = chk_idx_q;
        rem_wdata = orig_rdata;
      end
      ST_REPLY: begin
        rem_we    = hit_q;
        rem_waddr = best_q;
        rem_wdata = best_val_q - req;
      end
      default: begin
        rem_we = 1'b0;
      end
    endcase
  end

  cfa_ram #(
    .Width (SizeBits),
    .Depth (MaxChunks)
  ) u_orig_ram (
    .clk_i   (clk_i),
    .we_i    (orig_we),
    .waddr_i (AddrW'(item_q.slot)),
    .wdata_i (req),
    .raddr_i (orig_raddr),
    .rdata_o (orig_rdata)
  );

  cfa_ram #(
    .Width (SizeBits),
    .Depth (MaxChunks)
  ) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .raddr_i (cnt_q[AddrW-1:0]),
    .rdata_o (rem_rdata)
  );

  // Shared compare unit, fed one slot per cycle
  cfa_fit_cmp #(
    .SizeBits (SizeBits)
  ) u_fit_cmp (
    .fit_mode_i (fit_mode_q),
    .hit_i      (hit_q),
    .rem_i      (rem_rdata),
    .req_i      (req),
    .best_i     (best_val_q),
    .take_o     (take)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    chk_vld_d  = 1'b0;
    hit_d      = hit_q;
    best_d     = best_q;
    best_val_d = best_val_q;
    done_d     = 1'b0;
    result_d   = result_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = '0;
          hit_d = 1'b0;
          if (item_i.opcode == OP_WRITE) begin
            state_d = ST_WRITE;
          end else if (item_i.opcode == OP_RESTORE) begin
            state_d = ST_RESTORE;
          end else if (item_i.opcode == OP_ALLOC) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_WRITE: begin
        state_d = ST_IDLE;
      end
      ST_RESTORE: begin
        chk_vld_d = issue;
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end else if (!chk_vld_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        chk_vld_d = issue;
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end else if (!chk_vld_q) begin
          state_d = ST_FETCH;
        end
        if (chk_vld_q && take) begin
          hit_d      = 1'b1;
          best_d     = chk_idx_q;
          best_val_d = rem_rdata;
        end
      end
      ST_FETCH: begin
        state_d = ST_REPLY;
      end
      ST_REPLY: begin
        state_d                   = ST_IDLE;
        done_d                    = 1'b1;
        result_d.found            = hit_q;
        result_d.chosen_slot      = hit_q ? SlotW'(best_q) : '0;
        result_d.remaining_before = hit_q ? FieldW'(best_val_q) : '0;
        result_d.original_size    = hit_q ? FieldW'(orig_rdata) : '0;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      chk_vld_q  <= 1'b0;
      hit_q      <= 1'b0;
      done_q     <= 1'b0;
      fit_mode_q <= FIT_FIRST;
      chunks_q   <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      chk_vld_q <= chk_vld_d;
      hit_q     <= hit_d;
      done_q    <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_FIT_MODE) begin
          fit_mode_q <= cfg_data_i[FitW-1:0];
        end else if (cfg_index_i == CFG_CHUNKS) begin
          chunks_q <= cfg_data_i[ChunksW-1:0];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    chk_idx_q  <= cnt_q[AddrW-1:0];
    best_q     <= best_d;
    best_val_q <= best_val_d;
    result_q   <= result_d;
  end

endmodule

[rtl/cfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cfa_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/cfa_fit_cmp.sv]
// Fit compare unit: decides whether the chunk under scan replaces the current pick.
// Depends on cfa_pkg.
module cfa_fit_cmp import cfa_pkg::*; #(
  parameter int unsigned SizeBits = SizeBitsDef
) (
  input  logic [FitW-1:0]     fit_mode_i,
  input  logic                hit_i,
  input  logic [SizeBits-1:0] rem_i,
  input  logic [SizeBits-1:0] req_i,
  input  logic [SizeBits-1:0] best_i,
  output logic                take_o
);

  logic fits;

  assign fits = (rem_i >= req_i);

  // First fitting chunk always wins; later ones only on a strictly better size
  always_comb begin
    take_o = 1'b0;
    if (fits) begin
      if (!hit_i) begin
        take_o = 1'b1;
      end else if (fit_mode_i == FIT_BEST) begin
        take_o = (rem_i < best_i);
      end else if (fit_mode_i == FIT_WORST) begin
        take_o = (rem_i > best_i);
      end
    end
  end

endmodule

[tb/sv/cfa_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the chunk fit allocator: follows command and register transfers,
// keeps its own copy of the chunk tables and checks every allocation result.
// Depends on cfa_pkg.
module cfa_checker import cfa_pkg::*; #(
  parameter int unsigned Chunks = MaxChunksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  cfa_item_t           item_i,
  input  logic                done_i,
  input  cfa_result_t         result_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  results_o,
  output int                  placed_o
);

  // Shadow chunk tables and registers
  logic [FieldW-1:0]  orig_size_q [Chunks];
  logic [FieldW-1:0]  remain_q    [Chunks];
  logic [FitW-1:0]    fit_q;
  logic [ChunksW-1:0] chunks_q;

  // Placements still waiting for their result transfer, oldest first
  cfa_result_t placements_q [$];
  cfa_result_t want;

  // Scan the active slots under the current policy and cut the chosen chunk
  function automatic cfa_result_t place_request(input logic [FieldW-1:0] req);
    int unsigned span;
    int unsigned pick;
    logic        hit;
    logic        settled;
    cfa_result_t res;
    span    = (chunks_q > Chunks) ? Chunks : chunks_q;
    pick    = 0;
    hit     = 1'b0;
    settled = 1'b0;
    res     = '0;
    for (int unsigned i = 0; i < span; i++) begin
      if (!settled && remain_q[i] >= req) begin
        if (!hit) begin
          hit     = 1'b1;
          pick    = i;
          // first fit and the unused code stop at the first chunk that fits
          settled = (fit_q != FIT_BEST) && (fit_q != FIT_WORST);
        end else if (fit_q == FIT_BEST && remain_q[i] < remain_q[pick]) begin
          pick = i;
        end else if (fit_q == FIT_WORST && remain_q[i] > remain_q[pick]) begin
          pick = i;
        end
      end
    end
    if (hit) begin
      res.found            = 1'b1;
      res.chosen_slot      = pick[SlotW-1:0];
      res.remaining_before = remain_q[pick];
      res.original_size    = orig_size_q[pick];
      remain_q[pick]       = remain_q[pick] - req;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input cfa_result_t exp_r,
                               input cfa_result_t got_r);
    errors_o++;
    if (errors_o <= 10) begin
      $display("[%0t] %s", $time, what);
      $display("  expected found=%0d slot=%0d before=%0d original=%0d",
               exp_r.found, exp_r.chosen_slot, exp_r.remaining_before, exp_r.original_size);
      $display("  actual   found=%0d slot=%0d before=%0d original=%0d",
               got_r.found, got_r.chosen_slot, got_r.remaining_before, got_r.original_size);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Chunks; i++) begin
        orig_size_q[i] = '0;
        remain_q[i]    = '0;
      end
      fit_q    = FIT_FIRST;
      chunks_q = '0;
      placements_q.delete();
      errors_o  = 0;
      pending_o = 0;
      results_o = 0;
      placed_o  = 0;
    end else begin
      // Register write transfer
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_FIT_MODE: fit_q = cfg_data_i[FitW-1:0];
          CFG_CHUNKS:   chunks_q = cfg_data_i[ChunksW-1:0];
          default: ;
        endcase
      end

      // Result transfer: compare with the oldest placement before any new push
      if (done_i) begin
        if (placements_q.size() == 0) begin
          flag_mismatch("result with no allocation outstanding", '0, result_i);
        end else begin
          want = placements_q.pop_front();
          results_o++;
          if (want.found) placed_o++;
          if (result_i.found !== want.found ||
              result_i.chosen_slot !== want.chosen_slot ||
              result_i.remaining_before !== want.remaining_before ||
              result_i.original_size !== want.original_size) begin
            flag_mismatch("allocation result mismatch", want, result_i);
          end
        end
      end

      // Command transfer
      if (start_i && !busy_i) begin
        case (item_i.opcode)
          OP_WRITE: begin
            orig_size_q[item_i.slot] = item_i.size;
            remain_q[item_i.slot]    = item_i.size;
          end
          OP_RESTORE: begin
            for (int i = 0; i < Chunks; i++) remain_q[i] = orig_size_q[i];
          end
          OP_ALLOC: placements_q.push_back(place_request(item_i.size));
          default: ;
        endcase
      end
      pending_o = placements_q.size();
    end
  end

endmodule

[tb/sv/tb_chunk_fit_allocator.sv]
`timescale 1ns / 1ps
// Top of the chunk fit allocator testbench: clock, reset, command and register
// stimulus, and the verdict. Depends on cfa_pkg, chunk_fit_allocator and cfa_checker.
module tb_chunk_fit_allocator;
  import cfa_pkg::*;

  localparam int unsigned Chunks        = MaxChunksDef;
  localparam int unsigned SettleCycles  = Chunks + 8;
  localparam int unsigned CycleLimit    = 400000;
  localparam int unsigned Phases        = 12;
  localparam int unsigned ItemsPerPhase = 162;
  localparam logic [OpW-1:0]  OpUnused  = 2'd3;
  localparam logic [FitW-1:0] FitUnused = 2'd3;

  logic                clk;
  logic                rst_n;
  logic                start;
  cfa_item_t           item;
  logic                busy;
  logic                done;
  cfa_result_t         result;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int          errors;
  int          pending;
  int          results;
  int          placed;
  int unsigned cycles = 0;
  int unsigned commands = 0;
  int unsigned reg_writes = 0;
  int unsigned burst_left = 0;

  // Sizes last written per slot, used to aim requests and make ties
  logic [FieldW-1:0] sizes_seen [Chunks];
  logic [FieldW-1:0] seed_sizes [Chunks];

  chunk_fit_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .item_i      (item),
    .busy_o      (busy),
    .done_o      (done),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  cfa_checker #(.Chunks(Chunks)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item),
    .done_i      (done),
    .result_i    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results),
    .placed_o    (placed)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic cfa_item_t cmd_of(input logic [OpW-1:0] op, input int unsigned slot,
                                       input logic [FieldW-1:0] size);
    cfa_item_t c;
    c.opcode = op;
    c.slot   = slot[SlotW-1:0];
    c.size   = size;
    return c;
  endfunction

  // Mostly allocations aimed near the chunk sizes, with writes, restores and noise
  function automatic cfa_item_t random_cmd();
    cfa_item_t   c;
    int unsigned roll;
    roll   = $urandom_range(0, 99);
    c.slot = SlotW'($urandom_range(0, Chunks - 1));
    c.size = FieldW'($urandom);
    if (roll < 62) begin
      c.opcode = OP_ALLOC;
      case ($urandom_range(0, 5))
        0: c.size = '0;
        1: c.size = FieldW'($urandom_range(1, 255));
        2: c.size = FieldW'($urandom_range(1, 4095));
        3: c.size = sizes_seen[$urandom_range(0, Chunks - 1)];
        4: c.size = sizes_seen[$urandom_range(0, Chunks - 1)] >> $urandom_range(1, 4);
        default: ;
      endcase
    end else if (roll < 88) begin
      c.opcode = OP_WRITE;
      case ($urandom_range(0, 3))
        0: c.size = sizes_seen[$urandom_range(0, Chunks - 1)];
        1: c.size = FieldW'($urandom_range(0, 4095));
        default: ;
      endcase
    end else if (roll < 96) begin
      c.opcode = OP_RESTORE;
    end else begin
      c.opcode = OpUnused;
    end
    return c;
  endfunction

  // One command transfer; bursts of random length with random gaps between them
  task automatic issue(input cfa_item_t cmd);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 30);
    end
    burst_left--;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= cmd;
    do @(posedge clk); while (busy);
    commands++;
    if (cmd.opcode == OP_WRITE) sizes_seen[cmd.slot] = cmd.size;
  endtask

  // Wait for every result, then let a trailing write or restore finish
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Both registers, written back to back while the block is idle
  task automatic configure(input logic [FitW-1:0] fit, input logic [ChunksW-1:0] span);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_FIT_MODE;
    cfg_data  <= CfgDataW'(fit);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_CHUNKS;
    cfg_data  <= CfgDataW'(span);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes += 2;
  endtask

  initial begin
    logic [ChunksW-1:0] span;
    rst_n     = 1'b0;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FIT_MODE;
    cfg_data  = '0;
    seed_sizes = '{16'd0, 16'hFFFF, 16'd300, 16'd100, 16'd300, 16'd5000, 16'd100, 16'd42,
                   16'hFFFF, 16'd1, 16'd7, 16'd300, 16'd2048, 16'd100, 16'd9999, 16'd12345};
    for (int i = 0; i < Chunks; i++) sizes_seen[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: no chunks in play after reset, so nothing can be placed
    issue(cmd_of(OP_ALLOC, 0, 16'd100));
    for (int i = 0; i < Chunks; i++) issue(cmd_of(OP_WRITE, i, seed_sizes[i]));
    issue(cmd_of(OpUnused, Chunks - 1, 16'hFFFF));

    // First fit: zero request on an empty chunk, full-size requests until none fits
    configure(FIT_FIRST, ChunksW'(Chunks));
    issue(cmd_of(OP_ALLOC, 0, 16'd0));
    issue(cmd_of(OP_ALLOC, 0, 16'hFFFF));
    issue(cmd_of(OP_ALLOC, 0, 16'hFFFF));
    issue(cmd_of(OP_ALLOC, 0, 16'hFFFF));
    issue(cmd_of(OP_RESTORE, 0, 16'd0));

    // Best fit with ties on equal sizes, then worst fit past the slot count
    configure(FIT_BEST, ChunksW'(Chunks));
    issue(cmd_of(OP_ALLOC, 0, 16'd100));
    issue(cmd_of(OP_ALLOC, 0, 16'd100));
    configure(FIT_WORST, '1);
    issue(cmd_of(OP_ALLOC, 0, 16'd1));
    issue(cmd_of(OP_ALLOC, 0, 16'd0));

    // Unused policy code on a single empty chunk
    configure(FitUnused, ChunksW'(1));
    issue(cmd_of(OP_ALLOC, 0, 16'd1));
    issue(cmd_of(OP_ALLOC, 0, 16'd0));

    // Random phases, each under its own policy and slot count
    for (int p = 0; p < Phases; p++) begin
      case (p)
        0: span = ChunksW'(Chunks);
        1: span = '0;
        2: span = ChunksW'(1);
        3: span = '1;
        4: span = ChunksW'(Chunks + 1);
        default: span = ChunksW'($urandom_range(2, Chunks));
      endcase
      configure(FitW'(p % 4), span);
      repeat (ItemsPerPhase) issue(random_cmd());
    end
    drain();

    $display("Sent %0d commands and %0d register writes across first, best, worst fit",
             commands, reg_writes);
    $display("and the unused policy code; %0d allocations checked, %0d placed, %0d refused.",
             results, placed, results - placed);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
